[rtl/tsse_pkg.sv]
// Shared types, constants and register codes for the touch slider scroll encoder.
// No dependencies; every other file in rtl/ imports this package.
package tsse_pkg;

    localparam int PAD_BITS       = 4;
    localparam int PAD_COUNT      = 4;
    localparam int POS_W          = 2;
    localparam int TIME_W         = 32;
    localparam int LIMIT_W        = 16;
    localparam int SCAN_CNT_W     = 4;
    localparam int TICKS_W        = 4;
    localparam int TICK_CNT_W     = 5;
    localparam int MAX_RESULTS    = 30;
    localparam int MIN_TICKS      = 1;
    localparam int MAX_TICKS      = 10;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_SCANS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_FOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_FIVE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MOVE_TICKS  = 3'd6;

    // Register reset values
    localparam logic [SCAN_CNT_W-1:0] RST_STABLE_SCANS      = 4'd1;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT_ONE   = 16'd35;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT_TWO   = 16'd60;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT_THREE = 16'd90;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT_FOUR  = 16'd130;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT_FIVE  = 16'd200;
    localparam logic [TICKS_W-1:0]    RST_FIRST_MOVE_TICKS  = 4'd2;

    // Ticks per step for each speed band, fastest first
    localparam logic [TICKS_W-1:0] TICKS_BAND_ONE   = 4'd10;
    localparam logic [TICKS_W-1:0] TICKS_BAND_TWO   = 4'd8;
    localparam logic [TICKS_W-1:0] TICKS_BAND_THREE = 4'd6;
    localparam logic [TICKS_W-1:0] TICKS_BAND_FOUR  = 4'd4;
    localparam logic [TICKS_W-1:0] TICKS_BAND_FIVE  = 4'd2;
    localparam logic [TICKS_W-1:0] TICKS_BAND_SLOW  = 4'd1;

    typedef struct packed {
        logic [PAD_BITS-1:0] pad_touched;
        logic [TIME_W-1:0]   timestamp_ms;
    } in_item_t;

    typedef struct packed {
        logic scroll_up;
        logic last_tick;
    } out_item_t;

    typedef struct packed {
        logic [SCAN_CNT_W-1:0] stable_scans;
        logic [LIMIT_W-1:0]    speed_limit_one;
        logic [LIMIT_W-1:0]    speed_limit_two;
        logic [LIMIT_W-1:0]    speed_limit_three;
        logic [LIMIT_W-1:0]    speed_limit_four;
        logic [LIMIT_W-1:0]    speed_limit_five;
        logic [TICKS_W-1:0]    first_move_ticks;
    } cfg_t;

    // One burst of ticks in one direction, handed from front to back end
    typedef struct packed {
        logic                  up;
        logic [TICK_CNT_W-1:0] count;
    } cmd_t;

endpackage

[rtl/touch_slider_scroll_encoder.sv]
// Touch slider scroll encoder: scans in, wheel ticks out.
// The first tick of a scan reaches the result ports through the command queue
// and the output register, then one tick per cycle while pop is held.
// Throughput: one scan per cycle while the command queue has room; a scan that
// moves the position gives the tick expander a burst of up to 30 ticks.
// Reset clears tracking state and queues and restores register defaults.
module touch_slider_scroll_encoder #(
    parameter int CMD_DEPTH = tsse_pkg::CMD_FIFO_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tsse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tsse_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  tsse_pkg::in_item_t                   scan,
    output logic                                 empty,
    input  logic                                 pop,
    output tsse_pkg::out_item_t                  tick
);
    import tsse_pkg::*;

    cfg_t cfg_reg;
    logic take;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_valid;
    cmd_t cmd_head;
    logic cmd_pop;

    assign take = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.stable_scans      <= RST_STABLE_SCANS;
            cfg_reg.speed_limit_one   <= RST_SPEED_LIMIT_ONE;
            cfg_reg.speed_limit_two   <= RST_SPEED_LIMIT_TWO;
            cfg_reg.speed_limit_three <= RST_SPEED_LIMIT_THREE;
            cfg_reg.speed_limit_four  <= RST_SPEED_LIMIT_FOUR;
            cfg_reg.speed_limit_five  <= RST_SPEED_LIMIT_FIVE;
            cfg_reg.first_move_ticks  <= RST_FIRST_MOVE_TICKS;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_STABLE_SCANS:      cfg_reg.stable_scans      <= cfg_data[SCAN_CNT_W-1:0];
                REG_SPEED_LIMIT_ONE:   cfg_reg.speed_limit_one   <= cfg_data[LIMIT_W-1:0];
                REG_SPEED_LIMIT_TWO:   cfg_reg.speed_limit_two   <= cfg_data[LIMIT_W-1:0];
                REG_SPEED_LIMIT_THREE: cfg_reg.speed_limit_three <= cfg_data[LIMIT_W-1:0];
                REG_SPEED_LIMIT_FOUR:  cfg_reg.speed_limit_four  <= cfg_data[LIMIT_W-1:0];
                REG_SPEED_LIMIT_FIVE:  cfg_reg.speed_limit_five  <= cfg_data[LIMIT_W-1:0];
                REG_FIRST_MOVE_TICKS:  cfg_reg.first_move_ticks  <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    tsse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .take     (take),
        .scan     (scan),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    tsse_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .valid (cmd_valid),
        .rdata (cmd_head)
    );

    tsse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .tick      (tick)
    );

endmodule

[rtl/tsse_front.sv]
// Front end: position decode, debounce, swipe tracking and tick burst sizing.
// Depends on tsse_pkg; writes one cmd_t per position change into the command queue.
module tsse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tsse_pkg::cfg_t    cfg,
    input  logic              take,
    input  tsse_pkg::in_item_t scan,
    output logic              cmd_push,
    output tsse_pkg::cmd_t    cmd
);
    import tsse_pkg::*;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } pos_t;

    function automatic pos_t find_position(input logic [PAD_BITS-1:0] pads);
        logic [2:0]       count;
        logic [3:0]       sum;
        logic [3:0]       rnd;
        logic [POS_W-1:0] p;
        pos_t             r;
        count = '0;
        sum   = '0;
        p     = '0;
        for (int i = 0; i < PAD_BITS; i++) begin
            if (pads[i] && (i < PAD_COUNT)) begin
                count = count + 3'd1;
                sum   = sum + 4'(i);
            end
        end
        case (count)
            3'd1: p = POS_W'(sum);
            3'd2: begin
                rnd = sum + 4'd1;
                p   = POS_W'(rnd >> 1);
            end
            3'd3: begin
                // rounded sum / 3 over the few sums that can occur
                rnd = sum + 4'd1;
                p   = (rnd >= 4'd6) ? POS_W'(2) : ((rnd >= 4'd3) ? POS_W'(1) : POS_W'(0));
            end
            3'd4: begin
                rnd = sum + 4'd2;
                p   = POS_W'(rnd >> 2);
            end
            default: p = '0;
        endcase
        if (int'(p) >= PAD_COUNT) begin
            p = POS_W'(PAD_COUNT - 1);
        end
        r.valid = (count != 3'd0);
        r.pos   = p;
        return r;
    endfunction

    function automatic logic in_band(input logic [TIME_W-1:0] el, input logic [LIMIT_W-1:0] lim);
        return (el[TIME_W-1:LIMIT_W] == '0) && (el[LIMIT_W-1:0] <= lim);
    endfunction

    logic                  held_valid_reg, held_valid_next;
    logic [POS_W-1:0]      held_pos_reg, held_pos_next;
    logic                  cand_valid_reg, cand_valid_next;
    logic [POS_W-1:0]      cand_pos_reg, cand_pos_next;
    logic [SCAN_CNT_W-1:0] cand_rep_reg, cand_rep_next;
    logic [TIME_W-1:0]     base_time_reg, base_time_next;
    logic                  base_valid_reg, base_valid_next;

    pos_t                  found;
    logic                  same;
    logic [SCAN_CNT_W-1:0] rep_a;
    logic                  settled;
    logic [TIME_W-1:0]     elapsed;
    logic [TICKS_W-1:0]    speed;
    logic [TICKS_W-1:0]    ticks;
    logic [POS_W-1:0]      steps;
    logic                  up;
    logic [TICK_CNT_W:0]   total;

    always_comb
    begin
        found = find_position(scan.pad_touched);
        same  = (found.valid == cand_valid_reg) && (!found.valid || found.pos == cand_pos_reg);

        cand_valid_next = cand_valid_reg;
        cand_pos_next   = cand_pos_reg;
        if (!same) begin
            cand_valid_next = found.valid;
            cand_pos_next   = found.valid ? found.pos : '0;
            rep_a           = SCAN_CNT_W'(1);
        end else if (cand_rep_reg != '1) begin
            rep_a = cand_rep_reg + SCAN_CNT_W'(1);
        end else begin
            rep_a = cand_rep_reg;
        end
        settled = (rep_a >= cfg.stable_scans);

        // speed band from time since the last move
        elapsed = scan.timestamp_ms - base_time_reg;
        if (in_band(elapsed, cfg.speed_limit_one)) begin
            speed = TICKS_BAND_ONE;
        end else if (in_band(elapsed, cfg.speed_limit_two)) begin
            speed = TICKS_BAND_TWO;
        end else if (in_band(elapsed, cfg.speed_limit_three)) begin
            speed = TICKS_BAND_THREE;
        end else if (in_band(elapsed, cfg.speed_limit_four)) begin
            speed = TICKS_BAND_FOUR;
        end else if (in_band(elapsed, cfg.speed_limit_five)) begin
            speed = TICKS_BAND_FIVE;
        end else begin
            speed = TICKS_BAND_SLOW;
        end
        ticks = base_valid_reg ? speed : cfg.first_move_ticks;
        if (ticks < TICKS_W'(MIN_TICKS)) begin
            ticks = TICKS_W'(MIN_TICKS);
        end else if (ticks > TICKS_W'(MAX_TICKS)) begin
            ticks = TICKS_W'(MAX_TICKS);
        end

        up    = (cand_pos_next < held_pos_reg);
        steps = up ? (held_pos_reg - cand_pos_next) : (cand_pos_next - held_pos_reg);
        total = (TICK_CNT_W + 1)'(steps) * (TICK_CNT_W + 1)'(ticks);
        if (total > (TICK_CNT_W + 1)'(MAX_RESULTS)) begin
            total = (TICK_CNT_W + 1)'(MAX_RESULTS);
        end

        held_valid_next = held_valid_reg;
        held_pos_next   = held_pos_reg;
        base_time_next  = base_time_reg;
        base_valid_next = base_valid_reg;
        cand_rep_next   = settled ? cfg.stable_scans : rep_a;
        cmd_push        = 1'b0;

        if (settled) begin
            if (!cand_valid_next) begin
                // finger lifted: end the swipe
                held_valid_next = 1'b0;
                base_valid_next = 1'b0;
            end else if (!held_valid_reg) begin
                held_valid_next = 1'b1;
                held_pos_next   = cand_pos_next;
                base_time_next  = scan.timestamp_ms;
                base_valid_next = 1'b0;
            end else if (cand_pos_next != held_pos_reg) begin
                held_pos_next   = cand_pos_next;
                base_time_next  = scan.timestamp_ms;
                base_valid_next = 1'b1;
                cmd_push        = take;
            end
        end

        cmd.up    = up;
        cmd.count = total[TICK_CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_pos_reg   <= '0;
            cand_valid_reg <= 1'b0;
            cand_pos_reg   <= '0;
            cand_rep_reg   <= '0;
            base_time_reg  <= '0;
            base_valid_reg <= 1'b0;
        end else if (take) begin
            held_valid_reg <= held_valid_next;
            held_pos_reg   <= held_pos_next;
            cand_valid_reg <= cand_valid_next;
            cand_pos_reg   <= cand_pos_next;
            cand_rep_reg   <= cand_rep_next;
            base_time_reg  <= base_time_next;
            base_valid_reg <= base_valid_next;
        end
    end

endmodule

[rtl/tsse_cmd_fifo.sv]
// Short register queue of tick bursts between front and back end.
// Depends on tsse_pkg for cmd_t.
module tsse_cmd_fifo #(
    parameter int DEPTH = tsse_pkg::CMD_FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsse_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tsse_pkg::cmd_t rdata
);
    import tsse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/tsse_back.sv]
// Back end: expands each tick burst into wheel ticks, one per cycle unless pop stalls.
// Depends on tsse_pkg; drains tsse_cmd_fifo into a one-entry output register.
module tsse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  tsse_pkg::cmd_t       cmd,
    output logic                 cmd_pop,
    output logic                 empty,
    input  logic                 pop,
    output tsse_pkg::out_item_t  tick
);
    import tsse_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg;
    logic [TICK_CNT_W-1:0] sent_reg, sent_next;
    logic                  emit;
    logic                  last;

    assign empty = !out_valid_reg;
    assign tick  = out_reg;

    always_comb
    begin
        // advance when the output slot is free or being drained this cycle
        emit           = cmd_valid && (!out_valid_reg || pop);
        last           = ((sent_reg + TICK_CNT_W'(1)) == cmd.count);
        cmd_pop        = emit && last;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            sent_next      = last ? '0 : sent_reg + TICK_CNT_W'(1);
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sent_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            sent_reg      <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_reg.scroll_up <= cmd.up;
            out_reg.last_tick <= last;
        end
    end

endmodule

[tb/touch_slider_scroll_encoder_test.sv]
// Self-checking testbench for touch_slider_scroll_encoder: scans go in, wheel ticks are
// checked against a predictor of slider position, debounce and swipe speed.
// Depends on rtl/tsse_pkg.sv and rtl/touch_slider_scroll_encoder.sv.
`timescale 1ns / 1ps

module touch_slider_scroll_encoder_test;
    import tsse_pkg::*;

    localparam int PREDICTED     = -1;   // row is checked against the predictor
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_SCANS   = 50;

    typedef struct {
        logic [PAD_BITS-1:0] pads;
        logic [TIME_W-1:0]   stamp;
        int                  want_ticks;
        logic                want_up;
    } scan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    in_item_t               scan;
    logic                   empty;
    logic                   pop;
    out_item_t              tick;

    // Predictor copy of the registers and tracking state
    cfg_t                  shadow_cfg;
    logic                  held_valid;
    logic [POS_W-1:0]      held_pos;
    logic                  cand_valid;
    logic [POS_W-1:0]      cand_pos;
    logic [SCAN_CNT_W-1:0] cand_reps;
    logic [TIME_W-1:0]     base_time;
    logic                  base_valid;

    out_item_t   pending_ticks[$];
    int          error_count;
    int          scans_sent;
    logic        quiet;
    logic        hold_request;
    logic [31:0] now_ms;

    // Opening scans, run with the reset settings
    scan_row_t opening_scans [0:24] = '{
        '{4'b0000, 32'd0,          0,         1'b0},  // no touch
        '{4'b0001, 32'd100,        0,         1'b0},  // first touch sets the base
        '{4'b1000, 32'd120,        6,         1'b0},  // first move, three steps
        '{4'b0001, 32'd130,        30,        1'b1},  // fastest band, thirty ticks, right at the cap
        '{4'b0010, 32'd1130,       1,         1'b0},  // slowest band
        '{4'b1111, 32'd1230,       PREDICTED, 1'b0},
        '{4'b0000, 32'd1240,       0,         1'b0},  // release
        '{4'b1100, 32'd1250,       0,         1'b0},
        '{4'b1010, 32'd1260,       PREDICTED, 1'b0},
        '{4'b0110, 32'd1300,       PREDICTED, 1'b0},
        '{4'b0101, 32'd1335,       PREDICTED, 1'b0},
        '{4'b0111, 32'd1340,       PREDICTED, 1'b0},
        '{4'b1011, 32'd1345,       PREDICTED, 1'b0},
        '{4'b1101, 32'd1350,       PREDICTED, 1'b0},
        '{4'b1110, 32'd1410,       PREDICTED, 1'b0},
        '{4'b1001, 32'd1420,       PREDICTED, 1'b0},
        '{4'b0011, 32'd1550,       PREDICTED, 1'b0},  // on the slowest limit
        '{4'b0100, 32'd1751,       PREDICTED, 1'b0},  // just past it
        '{4'b0000, 32'hFFFF_FF00,  0,         1'b0},
        '{4'b0001, 32'hFFFF_FFE0,  0,         1'b0},
        '{4'b0010, 32'hFFFF_FFF0,  2,         1'b0},
        '{4'b0100, 32'h0000_0013,  10,        1'b0},  // elapsed wraps to 35
        '{4'b1000, 32'h0000_004F,  PREDICTED, 1'b0},
        '{4'b0000, 32'hFFFF_FFFF,  0,         1'b0},
        '{4'b0000, 32'h0000_0000,  0,         1'b0}
    };

    touch_slider_scroll_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .scan      (scan),
        .empty     (empty),
        .pop       (pop),
        .tick      (tick)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Work out the ticks one scan causes and advance the tracking state
    task automatic predict_scan(input in_item_t s, output int total, output logic up);
        int               count;
        int               sum;
        int               mean;
        int               ticks;
        int               steps;
        logic             seen;
        logic             same;
        logic [POS_W-1:0] pos;
        logic [TIME_W-1:0] elapsed;
        count = 0;
        sum   = 0;
        total = 0;
        up    = 1'b0;
        pos   = '0;
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            if (s.pad_touched[i])
            begin
                count++;
                sum += i;
            end
        end
        seen = (count != 0);
        if (seen)
        begin
            mean = (sum + count / 2) / count;
            if (mean >= PAD_COUNT)
                mean = PAD_COUNT - 1;
            pos = POS_W'(mean);
        end

        same = (seen == cand_valid) && (!seen || pos == cand_pos);
        if (!same)
        begin
            cand_valid = seen;
            cand_pos   = seen ? pos : '0;
            cand_reps  = SCAN_CNT_W'(1);
        end
        else if (cand_reps < 15)
            cand_reps++;

        if (cand_reps >= shadow_cfg.stable_scans)
        begin
            cand_reps = shadow_cfg.stable_scans;
            if (!cand_valid)
            begin
                held_valid = 1'b0;
                base_valid = 1'b0;
            end
            else if (!held_valid)
            begin
                held_valid = 1'b1;
                held_pos   = cand_pos;
                base_time  = s.timestamp_ms;
                base_valid = 1'b0;
            end
            else if (cand_pos != held_pos)
            begin
                if (base_valid)
                begin
                    // first limit that matches decides, whatever their order
                    elapsed = s.timestamp_ms - base_time;
                    if (elapsed <= TIME_W'(shadow_cfg.speed_limit_one))
                        ticks = int'(TICKS_BAND_ONE);
                    else if (elapsed <= TIME_W'(shadow_cfg.speed_limit_two))
                        ticks = int'(TICKS_BAND_TWO);
                    else if (elapsed <= TIME_W'(shadow_cfg.speed_limit_three))
                        ticks = int'(TICKS_BAND_THREE);
                    else if (elapsed <= TIME_W'(shadow_cfg.speed_limit_four))
                        ticks = int'(TICKS_BAND_FOUR);
                    else if (elapsed <= TIME_W'(shadow_cfg.speed_limit_five))
                        ticks = int'(TICKS_BAND_FIVE);
                    else
                        ticks = int'(TICKS_BAND_SLOW);
                end
                else
                    ticks = int'(shadow_cfg.first_move_ticks);
                if (ticks < MIN_TICKS)
                    ticks = MIN_TICKS;
                if (ticks > MAX_TICKS)
                    ticks = MAX_TICKS;
                up    = (cand_pos < held_pos);
                steps = up ? int'(held_pos) - int'(cand_pos) : int'(cand_pos) - int'(held_pos);
                total = steps * ticks;
                if (total > MAX_RESULTS)
                    total = MAX_RESULTS;
                held_pos   = cand_pos;
                base_time  = s.timestamp_ms;
                base_valid = 1'b1;
            end
        end
    endtask

    // Offer one scan, wait for the transfer, then queue the ticks it should cause
    task automatic send_scan(input in_item_t s, input int want_ticks, input logic want_up);
        int   total;
        logic up;
        out_item_t t;
        if (!quiet && (scans_sent % 64) < 48 && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        scan <= s;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        scans_sent++;
        predict_scan(s, total, up);
        if (want_ticks != PREDICTED)
        begin
            total = want_ticks;
            up    = want_up;
        end
        for (int k = 0; k < total; k++)
        begin
            t.scroll_up = up;
            t.last_tick = (k == total - 1);
            pending_ticks.push_back(t);
        end
    endtask

    // Stop offering and hold until every queued tick has come out
    task automatic drain;
        push <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        logic [CFG_INDEX_W-1:0] regs [7];
        logic [CFG_DATA_W-1:0]  vals [7];
        regs = '{REG_STABLE_SCANS, REG_SPEED_LIMIT_ONE, REG_SPEED_LIMIT_TWO,
                 REG_SPEED_LIMIT_THREE, REG_SPEED_LIMIT_FOUR, REG_SPEED_LIMIT_FIVE,
                 REG_FIRST_MOVE_TICKS};
        vals = '{CFG_DATA_W'(c.stable_scans), c.speed_limit_one, c.speed_limit_two,
                 c.speed_limit_three, c.speed_limit_four, c.speed_limit_five,
                 CFG_DATA_W'(c.first_move_ticks)};
        for (int i = 0; i < 7; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        shadow_cfg = c;
    endtask

    // Mostly held touches and releases that get past the debounce, some noise and jumps
    task automatic run_gestures(input int n_scans);
        int                  sent;
        int                  reps;
        int                  kind;
        int                  stable;
        logic [PAD_BITS-1:0] pads;
        in_item_t            s;
        sent = 0;
        while (sent < n_scans)
        begin
            kind   = $urandom_range(0, 9);
            stable = (shadow_cfg.stable_scans == 0) ? 1 : int'(shadow_cfg.stable_scans);
            reps   = stable + $urandom_range(0, 1);
            if ($urandom_range(0, 5) == 0)
                reps = $urandom_range(1, stable);   // bounce for at most the debounce count
            if (kind <= 5)
            begin
                if ($urandom_range(0, 1) == 1)
                    pads = PAD_BITS'(1 << $urandom_range(0, PAD_COUNT - 1));
                else
                    pads = PAD_BITS'($urandom_range(1, 15));
            end
            else if (kind <= 7)
                pads = '0;
            else
            begin
                pads = PAD_BITS'($urandom_range(0, 15));
                reps = 1;
                if (kind == 9)
                    now_ms = $urandom;
            end
            for (int r = 0; r < reps && sent < n_scans; r++)
            begin
                case ($urandom_range(0, 4))
                    0: now_ms += $urandom_range(0, 40);
                    1: now_ms += $urandom_range(30, 140);
                    2: now_ms += $urandom_range(120, 260);
                    3: now_ms += $urandom_range(0, 5);
                    default: now_ms += $urandom_range(0, 300);
                endcase
                s.pad_touched  = pads;
                s.timestamp_ms = now_ms;
                send_scan(s, PREDICTED, 1'b0);
                sent++;
            end
        end
    endtask

    // Tick sink: check each transfer, stall in bursts, or hold off for a long stretch
    initial
    begin : tick_sink
        int          hold_left;
        logic [31:0] rx_cycle;
        out_item_t   want;
        hold_left = 0;
        rx_cycle  = '0;
        pop       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_ticks.size() == 0)
                    report_mismatch($sformatf("tick up=%0b last=%0b with none pending",
                                              tick.scroll_up, tick.last_tick));
                else
                begin
                    want = pending_ticks.pop_front();
                    if (tick.scroll_up !== want.scroll_up)
                        report_mismatch($sformatf("scroll_up %0b, want %0b",
                                                  tick.scroll_up, want.scroll_up));
                    if (tick.last_tick !== want.last_tick)
                        report_mismatch($sformatf("last_tick %0b, want %0b",
                                                  tick.last_tick, want.last_tick));
                end
            end
            rx_cycle++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!quiet && rx_cycle[6:5] != 2'b11 && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 11);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : stimulus
        cfg_t     c;
        in_item_t s;
        rst_n        = 1'b0;
        push         = 1'b0;
        scan         = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        error_count  = 0;
        scans_sent   = 0;
        now_ms       = 32'd5000;

        shadow_cfg = '{RST_STABLE_SCANS, RST_SPEED_LIMIT_ONE, RST_SPEED_LIMIT_TWO,
                       RST_SPEED_LIMIT_THREE, RST_SPEED_LIMIT_FOUR, RST_SPEED_LIMIT_FIVE,
                       RST_FIRST_MOVE_TICKS};
        held_valid = 1'b0;
        held_pos   = '0;
        cand_valid = 1'b0;
        cand_pos   = '0;
        cand_reps  = '0;
        base_time  = '0;
        base_valid = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_scans[i])
        begin
            s.pad_touched  = opening_scans[i].pads;
            s.timestamp_ms = opening_scans[i].stamp;
            send_scan(s, opening_scans[i].want_ticks, opening_scans[i].want_up);
        end
        drain();

        // Reset settings; the sink holds off long enough for the block to fill up
        hold_request = 1'b1;
        run_gestures(PHASE_SCANS);
        drain();

        // Slowest debounce, every move within 65535 ms in the fastest band, largest first move
        c = '{4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd10};
        apply_settings(c);
        run_gestures(PHASE_SCANS);
        drain();

        // Zero debounce count, zero first move, limits out of order
        c = '{4'd0, 16'd0, 16'hFFFF, 16'd40, 16'd20, 16'd1, 4'd0};
        apply_settings(c);
        run_gestures(PHASE_SCANS);
        drain();

        // All limits zero, first move above the tick ceiling
        c = '{4'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd15};
        apply_settings(c);
        run_gestures(PHASE_SCANS);
        drain();

        c.stable_scans      = SCAN_CNT_W'($urandom_range(1, 4));
        c.speed_limit_one   = LIMIT_W'($urandom_range(0, 60));
        c.speed_limit_two   = LIMIT_W'($urandom_range(0, 120));
        c.speed_limit_three = LIMIT_W'($urandom_range(0, 180));
        c.speed_limit_four  = LIMIT_W'($urandom_range(0, 240));
        c.speed_limit_five  = LIMIT_W'($urandom_range(0, 300));
        c.first_move_ticks  = TICKS_W'($urandom_range(1, 10));
        apply_settings(c);
        run_gestures(PHASE_SCANS);
        drain();

        // Back to the defaults, with no idling on either side
        c = '{RST_STABLE_SCANS, RST_SPEED_LIMIT_ONE, RST_SPEED_LIMIT_TWO,
              RST_SPEED_LIMIT_THREE, RST_SPEED_LIMIT_FOUR, RST_SPEED_LIMIT_FIVE,
              RST_FIRST_MOVE_TICKS};
        apply_settings(c);
        quiet = 1'b1;
        run_gestures(PHASE_SCANS);

        push <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
